FILE: design/assert_macros.svh
// Assertion helpers for the ranger modules, used by uer_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define UER_ASSERT(lbl, clock, resetn, prop) \
  lbl: assert property (@(posedge clock) disable iff (!resetn) prop) \
    else $error("assertion failed");

`define UER_ASSERT_ALWAYS(lbl, clock, prop) \
  lbl: assert property (@(posedge clock) prop) \
    else $error("assertion failed");

`else

`define UER_ASSERT(lbl, clock, resetn, prop)

`define UER_ASSERT_ALWAYS(lbl, clock, prop)

`endif

`endif

FILE: design/uer_pkg.sv
`default_nettype none

package uer_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CHAN_W       = 2;
  localparam int CNT_W        = 16;
  localparam int REG_IDX_W    = 3;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_TRIGGER_TICKS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COUNT_DIVIDER = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RISE_TIMEOUT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH_TIMEOUT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_WIDTH     = 3'd4;

  localparam logic [CNT_W-1:0] RST_TRIGGER_TICKS = 16'd160;
  localparam logic [CNT_W-1:0] RST_COUNT_DIVIDER = 16'd256;
  localparam logic [CNT_W-1:0] RST_RISE_TIMEOUT  = 16'd60000;
  localparam logic [CNT_W-1:0] RST_WIDTH_TIMEOUT = 16'd60000;
  localparam logic [CNT_W-1:0] RST_MAX_WIDTH     = 16'd250;

  localparam logic [CNT_W-1:0] CODE_NO_ECHO    = 16'hFFFF;
  localparam logic [CNT_W-1:0] CODE_TOO_LONG   = 16'hFFFC;
  localparam logic [CNT_W-1:0] CODE_OVER_RANGE = 16'hFFF1;
  localparam logic [CNT_W-1:0] WIDTH_SAT       = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_RISE,
    PH_MEAS
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] trig_lim;
    logic [CNT_W-1:0] div_lim;
    logic [CNT_W-1:0] rise_timeout;
    logic [CNT_W-1:0] width_timeout;
    logic [CNT_W-1:0] max_width;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              func;
    logic [CHAN_W-1:0]       channel;
    logic [NUM_CHANNELS-1:0] echo_levels;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]        read_data;
    logic [NUM_CHANNELS-1:0] trigger_lines;
    logic                    busy_res;
    logic                    done_res;
  } result_t;

endpackage

`default_nettype wire

FILE: design/uer_cfg_regs.sv
`default_nettype none

module uer_cfg_regs
  import uer_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [REG_IDX_W-1:0] wr_index,
  input  wire logic [CNT_W-1:0]     wr_data,
  output cfg_t                      cfg
);

  logic [CNT_W-1:0] trigger_ticks_r;
  logic [CNT_W-1:0] count_divider_r;
  logic [CNT_W-1:0] rise_timeout_r;
  logic [CNT_W-1:0] width_timeout_r;
  logic [CNT_W-1:0] max_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= RST_TRIGGER_TICKS;
      count_divider_r <= RST_COUNT_DIVIDER;
      rise_timeout_r  <= RST_RISE_TIMEOUT;
      width_timeout_r <= RST_WIDTH_TIMEOUT;
      max_width_r     <= RST_MAX_WIDTH;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TRIGGER_TICKS: trigger_ticks_r <= wr_data;
        REG_COUNT_DIVIDER: count_divider_r <= wr_data;
        REG_RISE_TIMEOUT:  rise_timeout_r  <= wr_data;
        REG_WIDTH_TIMEOUT: width_timeout_r <= wr_data;
        REG_MAX_WIDTH:     max_width_r     <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // A zero trigger length or divider acts as one.
  always_comb begin
    cfg.trig_lim      = (trigger_ticks_r == '0) ? CNT_W'(1) : trigger_ticks_r;
    cfg.div_lim       = (count_divider_r == '0) ? CNT_W'(1) : count_divider_r;
    cfg.rise_timeout  = rise_timeout_r;
    cfg.width_timeout = width_timeout_r;
    cfg.max_width     = max_width_r;
  end

endmodule

`default_nettype wire

FILE: design/uer_core.sv
`default_nettype none

`include "assert_macros.svh"

module uer_core
  import uer_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fire,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output result_t    res
);

  phase_t                   phase_r, phase_nxt;
  logic [CHAN_W-1:0]        active_r, active_nxt;
  logic [CNT_W-1:0]         tick_r, tick_nxt;
  logic [CNT_W-1:0]         psc_r, psc_nxt;
  logic [CNT_W-1:0]         width_r, width_nxt;
  logic [CNT_W-1:0]         store_r [NUM_CHANNELS];
  logic                     store_we;
  logic [CNT_W-1:0]         store_val;

  logic                     level;
  logic [CNT_W-1:0]         tick_inc;
  logic [CNT_W-1:0]         psc_inc;
  logic                     is_tick;
  logic                     rise_to;
  logic                     meas_to;
  logic [NUM_CHANNELS-1:0]  chan_onehot;

  assign is_tick  = (item.func == FUNC_TICK);
  assign level    = item.echo_levels[active_r];
  assign tick_inc = tick_r + CNT_W'(1);
  assign psc_inc  = psc_r + CNT_W'(1);
  assign rise_to  = (tick_r >= cfg.rise_timeout);
  assign meas_to  = (tick_r >= cfg.width_timeout);

  // Next state of the measurement sequencer.
  always_comb begin
    phase_nxt  = phase_r;
    active_nxt = active_r;
    tick_nxt   = tick_r;
    psc_nxt    = psc_r;
    width_nxt  = width_r;
    store_we   = 1'b0;
    store_val  = width_r;
    case (item.func)
      FUNC_TICK: begin
        unique case (phase_r)
          PH_IDLE: begin
          end
          PH_TRIG: begin
            if (tick_inc >= cfg.trig_lim) begin
              phase_nxt = PH_RISE;
              tick_nxt  = '0;
            end else begin
              tick_nxt = tick_inc;
            end
          end
          PH_RISE: begin
            if (level) begin
              phase_nxt = PH_MEAS;
              tick_nxt  = '0;
              psc_nxt   = '0;
              width_nxt = '0;
            end else if (rise_to) begin
              phase_nxt = PH_IDLE;
              tick_nxt  = '0;
              store_we  = 1'b1;
              store_val = CODE_NO_ECHO;
            end else begin
              tick_nxt = tick_inc;
            end
          end
          PH_MEAS: begin
            if (level) begin
              if (psc_inc >= cfg.div_lim) begin
                psc_nxt = '0;
                if (width_r != WIDTH_SAT) begin
                  width_nxt = width_r + CNT_W'(1);
                end
              end else begin
                psc_nxt = psc_inc;
              end
              if (meas_to) begin
                phase_nxt = PH_IDLE;
                tick_nxt  = '0;
                store_we  = 1'b1;
                store_val = CODE_TOO_LONG;
              end else begin
                tick_nxt = tick_inc;
              end
            end else begin
              phase_nxt = PH_IDLE;
              tick_nxt  = '0;
              store_we  = 1'b1;
              store_val = (width_r > cfg.max_width) ? CODE_OVER_RANGE : width_r;
            end
          end
          default: begin
          end
        endcase
      end
      FUNC_START: begin
        if (phase_r == PH_IDLE) begin
          active_nxt = item.channel;
          phase_nxt  = PH_TRIG;
          tick_nxt   = '0;
          psc_nxt    = '0;
          width_nxt  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign chan_onehot = NUM_CHANNELS'(1) << active_nxt;

  // Result beat for this item, taken from the state it leaves behind.
  always_comb begin
    res.read_data     = (item.func == FUNC_READ) ? store_r[item.channel] : '0;
    res.trigger_lines = (phase_nxt == PH_TRIG) ? chan_onehot : '0;
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.done_res      = is_tick && store_we;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      active_r <= '0;
      tick_r   <= '0;
      psc_r    <= '0;
      width_r  <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        store_r[i] <= '0;
      end
    end else if (fire) begin
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
      tick_r   <= tick_nxt;
      psc_r    <= psc_nxt;
      width_r  <= width_nxt;
      if (store_we) begin
        store_r[active_r] <= store_val;
      end
    end
  end

  `UER_ASSERT(a_done_goes_idle, clk, rst_n, fire && res.done_res |=> phase_r == PH_IDLE)
  `UER_ASSERT(a_hold_without_fire, clk, rst_n, !fire |=> $stable(phase_r) && $stable(tick_r))
  `UER_ASSERT(a_start_from_idle, clk, rst_n,
    fire && item.func == FUNC_START && phase_r == PH_IDLE |=> phase_r == PH_TRIG)
  `UER_ASSERT(a_trig_one_line, clk, rst_n, fire |-> $onehot0(res.trigger_lines))

endmodule

`default_nettype wire

FILE: design/ultrasonic_echo_ranger.sv
// Four-channel ultrasonic echo ranger.
// Input beats on in_*: in_tuser is the function (tick, start, read), in_tdata
// carries the channel and the sampled echo levels. A tick beat advances the
// trigger, rise-wait and width-measure sequence by one tick; a start beat
// arms a channel when no measurement runs; a read beat returns the stored
// width or error code of a channel.
// Every input beat yields exactly one output beat on out_* with the read
// value, trigger line levels, busy and done flags.
// Each beat is held in the input register, then the sequencer logic feeds the
// output register. One beat per cycle is sustained while out_tready stays high.
// When out_tready is low the output register holds its beat while the input
// register still takes one more beat; in_tready then drops until the stall
// clears, and no beat is lost or repeated.
// Configuration writes on cfg_* are always taken; the user must keep them to
// idle periods, which the block does not enforce. Synchronous reset restores the
// default registers, idles the sequencer and clears all stored results to zero.
`default_nettype none

module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,  // channel[1:0], echo_levels[5:2], zero pad
  input  wire logic [1:0]           in_tuser,  // func[1:0]
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [23:0]               out_tdata, // read_data[15:0], trigger_lines[19:16],
                                               // busy_res[20], done_res[21], zero pad
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data
);

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    fire;

  assign cfg_ready = 1'b1;
  assign fire      = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || fire;

  uer_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  uer_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        item_valid_r <= in_tvalid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.func        <= in_tuser;
      item_r.channel     <= in_tdata[1:0];
      item_r.echo_levels <= in_tdata[5:2];
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.done_res, res_r.busy_res,
                       res_r.trigger_lines, res_r.read_data};

endmodule

`default_nettype wire

FILE: bench/ultrasonic_echo_ranger_tb.sv
`default_nettype none

module ultrasonic_echo_ranger_tb;
  import uer_pkg::*;

  localparam logic [1:0]           FUNC_NONE = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd5;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [1:0]             func;
    logic [CHAN_W-1:0]      chan;
    logic [3:0]             echo;
    logic                   typed;
    result_t                want;
    logic [REG_IDX_W-1:0]   idx;
    logic [CNT_W-1:0]       val;
  } row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic [1:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_data;

  ultrasonic_echo_ranger dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow copy of the ranger's registers and sequencer state.
  logic [CNT_W-1:0]  sim_trig_ticks;
  logic [CNT_W-1:0]  sim_divider;
  logic [CNT_W-1:0]  sim_rise_to;
  logic [CNT_W-1:0]  sim_width_to;
  logic [CNT_W-1:0]  sim_max_width;
  phase_t            sim_phase;
  logic [CHAN_W-1:0] sim_chan;
  logic [CNT_W-1:0]  sim_ticks;
  logic [CNT_W-1:0]  sim_prescale;
  logic [CNT_W-1:0]  sim_width;
  logic [CNT_W-1:0]  sim_store [NUM_CHANNELS];

  result_t     pending_readings [$];
  result_t     got;
  result_t     want;
  row_t        dir_rows [$];
  int unsigned mismatches;
  int unsigned beats_sent;
  int unsigned beats_taken;

  function automatic void store_reading(input logic [CNT_W-1:0] value);
    sim_store[sim_chan] = value;
    sim_phase = PH_IDLE;
    sim_ticks = '0;
  endfunction

  function automatic void ranger_step(input logic [1:0] func, input logic [CHAN_W-1:0] chan,
                                      input logic [3:0] echo, output result_t res);
    logic level;
    level = echo[sim_chan];
    res = '0;
    case (func)
      FUNC_TICK: begin
        case (sim_phase)
          PH_TRIG: begin
            sim_ticks = sim_ticks + 16'd1;
            if (sim_ticks >= sim_trig_ticks) begin
              sim_phase = PH_RISE;
              sim_ticks = '0;
            end
          end
          PH_RISE: begin
            if (level) begin
              sim_phase = PH_MEAS;
              sim_ticks = '0;
              sim_prescale = '0;
              sim_width = '0;
            end else if (sim_ticks >= sim_rise_to) begin
              store_reading(CODE_NO_ECHO);
              res.done_res = 1'b1;
            end else begin
              sim_ticks = sim_ticks + 16'd1;
            end
          end
          PH_MEAS: begin
            if (level) begin
              sim_prescale = sim_prescale + 16'd1;
              if (sim_prescale >= sim_divider) begin
                sim_prescale = '0;
                if (sim_width != WIDTH_SAT) sim_width = sim_width + 16'd1;
              end
              if (sim_ticks >= sim_width_to) begin
                store_reading(CODE_TOO_LONG);
                res.done_res = 1'b1;
              end else begin
                sim_ticks = sim_ticks + 16'd1;
              end
            end else begin
              store_reading((sim_width > sim_max_width) ? CODE_OVER_RANGE : sim_width);
              res.done_res = 1'b1;
            end
          end
          default: ;
        endcase
      end
      FUNC_START: begin
        if (sim_phase == PH_IDLE) begin
          sim_chan = chan;
          sim_phase = PH_TRIG;
          sim_ticks = '0;
          sim_prescale = '0;
          sim_width = '0;
        end
      end
      FUNC_READ: res.read_data = sim_store[chan];
      default: ;
    endcase
    res.trigger_lines = (sim_phase == PH_TRIG) ? (4'b0001 << sim_chan) : 4'b0000;
    res.busy_res = (sim_phase != PH_IDLE);
  endfunction

  function automatic row_t item_row(input logic [1:0] func, input logic [CHAN_W-1:0] chan,
                                    input logic [3:0] echo);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.func = func;
    r.chan = chan;
    r.echo = echo;
    return r;
  endfunction

  function automatic row_t want_row(input logic [1:0] func, input logic [CHAN_W-1:0] chan,
                                    input logic [3:0] echo, input logic [CNT_W-1:0] rd,
                                    input logic [3:0] trig, input logic busy);
    row_t r;
    r = item_row(func, chan, echo);
    r.typed = 1'b1;
    r.want.read_data = rd;
    r.want.trigger_lines = trig;
    r.want.busy_res = busy;
    r.want.done_res = 1'b0;
    return r;
  endfunction

  function automatic row_t reg_row(input logic [REG_IDX_W-1:0] idx,
                                   input logic [CNT_W-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic void compare_field(input string what, input logic [CNT_W-1:0] exp_v,
                                        input logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, what, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic send_item(input logic [1:0] func, input logic [CHAN_W-1:0] chan,
                           input logic [3:0] echo, input logic typed, input result_t typed_res);
    int unsigned gap;
    result_t     pred;
    gap = (beats_sent % 128 < 24) ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {2'b00, echo, chan};
    do @(posedge clk); while (!in_tready);
    ranger_step(func, chan, echo, pred);
    pending_readings.push_back(typed ? typed_res : pred);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TRIGGER_TICKS: sim_trig_ticks = val;
      REG_COUNT_DIVIDER: sim_divider = val;
      REG_RISE_TIMEOUT:  sim_rise_to = val;
      REG_WIDTH_TIMEOUT: sim_width_to = val;
      REG_MAX_WIDTH:     sim_max_width = val;
      default: ;
    endcase
  endtask

  // Echo word with the active channel's bit forced and the other bits random.
  function automatic logic [3:0] echo_word(input logic level);
    logic [3:0] e;
    e = 4'($urandom_range(0, 15));
    e[sim_chan] = level;
    return e;
  endfunction

  // One well-formed measurement: start, low ticks through the trigger and the
  // rise wait, high ticks for the pulse, a falling edge, then, on three draws in four, a read back.
  task automatic measure_once();
    logic [CHAN_W-1:0] chan;
    int unsigned       lows;
    int unsigned       highs;
    int unsigned       span;
    chan = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
    send_item(FUNC_START, chan, 4'($urandom_range(0, 15)), 1'b0, '0);
    span = (sim_rise_to > 20) ? 20 : sim_rise_to + 2;
    lows = ((sim_trig_ticks == 0) ? 1 : sim_trig_ticks) + $urandom_range(0, span);
    if (lows > 40) lows = 40;
    span = (sim_width_to > 36) ? 36 : sim_width_to + 3;
    highs = $urandom_range(0, span);
    repeat (lows) send_item(FUNC_TICK, 2'($urandom_range(0, 3)), echo_word(1'b0), 1'b0, '0);
    repeat (highs) send_item(FUNC_TICK, 2'($urandom_range(0, 3)), echo_word(1'b1), 1'b0, '0);
    send_item(FUNC_TICK, 2'($urandom_range(0, 3)), echo_word(1'b0), 1'b0, '0);
    if ($urandom_range(0, 3) != 0)
      send_item(FUNC_READ, chan, 4'($urandom_range(0, 15)), 1'b0, '0);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("ultrasonic_echo_ranger_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.read_data     = out_tdata[15:0];
      got.trigger_lines = out_tdata[19:16];
      got.busy_res      = out_tdata[20];
      got.done_res      = out_tdata[21];
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        compare_field("read_data", want.read_data, got.read_data);
        compare_field("trigger_lines", 16'(want.trigger_lines), 16'(got.trigger_lines));
        compare_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
        compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
      end
    end
  end

  // Result side: random stalls, recurring stall-free stretches, and one long hold-off.
  initial begin
    int unsigned hold;
    out_tready <= 1'b0;
    beats_taken = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (beats_taken == 300) hold = 150;
      else if (beats_taken % 128 >= 100) hold = 0;
      else hold = $urandom_range(0, 9);
      if (hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      beats_taken++;
    end
  end

  initial begin
    int unsigned stop_at;
    row_t        r;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= FUNC_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TRIGGER_TICKS;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    mismatches = 0;
    beats_sent = 0;
    sim_trig_ticks = RST_TRIGGER_TICKS;
    sim_divider    = RST_COUNT_DIVIDER;
    sim_rise_to    = RST_RISE_TIMEOUT;
    sim_width_to   = RST_WIDTH_TIMEOUT;
    sim_max_width  = RST_MAX_WIDTH;
    sim_phase      = PH_IDLE;
    sim_chan       = '0;
    sim_ticks      = '0;
    sim_prescale   = '0;
    sim_width      = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) sim_store[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset contents, the unused function code, and a start while busy.
    dir_rows.push_back(want_row(FUNC_READ, 2'd0, 4'h0, 16'h0000, 4'b0000, 1'b0));
    dir_rows.push_back(want_row(FUNC_READ, 2'd3, 4'hF, 16'h0000, 4'b0000, 1'b0));
    dir_rows.push_back(want_row(FUNC_NONE, 2'd1, 4'hF, 16'h0000, 4'b0000, 1'b0));
    dir_rows.push_back(want_row(FUNC_START, 2'd2, 4'h0, 16'h0000, 4'b0100, 1'b1));
    dir_rows.push_back(want_row(FUNC_START, 2'd1, 4'h0, 16'h0000, 4'b0100, 1'b1));
    dir_rows.push_back(item_row(FUNC_TICK, 2'd0, 4'h0));
    // Zero trigger length and divider, short timeouts: no echo, then too long.
    dir_rows.push_back(reg_row(REG_TRIGGER_TICKS, 16'h0000));
    dir_rows.push_back(reg_row(REG_COUNT_DIVIDER, 16'h0000));
    dir_rows.push_back(reg_row(REG_RISE_TIMEOUT, 16'd1));
    dir_rows.push_back(reg_row(REG_WIDTH_TIMEOUT, 16'd2));
    dir_rows.push_back(reg_row(REG_MAX_WIDTH, 16'hFFFF));
    dir_rows.push_back(reg_row(REG_SPARE, 16'hFFFF));
    repeat (3) dir_rows.push_back(item_row(FUNC_TICK, 2'd0, 4'h0));
    dir_rows.push_back(want_row(FUNC_READ, 2'd2, 4'h0, CODE_NO_ECHO, 4'b0000, 1'b0));
    dir_rows.push_back(item_row(FUNC_START, 2'd1, 4'h0));
    repeat (5) dir_rows.push_back(item_row(FUNC_TICK, 2'd2, 4'hF));
    dir_rows.push_back(want_row(FUNC_READ, 2'd1, 4'h0, CODE_TOO_LONG, 4'b0000, 1'b0));
    // A width of one against a limit of zero is over range.
    dir_rows.push_back(reg_row(REG_TRIGGER_TICKS, 16'd1));
    dir_rows.push_back(reg_row(REG_COUNT_DIVIDER, 16'd1));
    dir_rows.push_back(reg_row(REG_WIDTH_TIMEOUT, 16'hFFFF));
    dir_rows.push_back(reg_row(REG_MAX_WIDTH, 16'h0000));
    dir_rows.push_back(item_row(FUNC_START, 2'd3, 4'h0));
    dir_rows.push_back(item_row(FUNC_TICK, 2'd1, 4'h0));
    dir_rows.push_back(item_row(FUNC_TICK, 2'd1, 4'h8));
    dir_rows.push_back(item_row(FUNC_TICK, 2'd1, 4'h8));
    dir_rows.push_back(item_row(FUNC_TICK, 2'd1, 4'h7));
    dir_rows.push_back(want_row(FUNC_READ, 2'd3, 4'h0, CODE_OVER_RANGE, 4'b0000, 1'b0));

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_REG) write_reg(r.idx, r.val);
      else send_item(r.func, r.chan, r.echo, r.typed, r.want);
    end

    for (int p = 0; p < 7; p++) begin
      case (p)
        1: begin
          write_reg(REG_TRIGGER_TICKS, 16'd1);
          write_reg(REG_COUNT_DIVIDER, 16'hFFFF);
          write_reg(REG_RISE_TIMEOUT, 16'hFFFF);
          write_reg(REG_WIDTH_TIMEOUT, 16'hFFFF);
          write_reg(REG_MAX_WIDTH, 16'hFFFF);
        end
        3: begin
          write_reg(REG_TRIGGER_TICKS, 16'hFFFF);
          write_reg(REG_COUNT_DIVIDER, 16'd1);
          write_reg(REG_RISE_TIMEOUT, 16'd3);
          write_reg(REG_WIDTH_TIMEOUT, 16'd10);
          write_reg(REG_MAX_WIDTH, 16'd5);
        end
        default: begin
          write_reg(REG_TRIGGER_TICKS, 16'($urandom_range(1, 6)));
          write_reg(REG_COUNT_DIVIDER, 16'($urandom_range(1, 4)));
          write_reg(REG_RISE_TIMEOUT, 16'($urandom_range(1, 12)));
          write_reg(REG_WIDTH_TIMEOUT, 16'($urandom_range(2, 30)));
          write_reg(REG_MAX_WIDTH, (p == 2) ? 16'h0000 : 16'($urandom_range(0, 15)));
        end
      endcase
      stop_at = beats_sent + ((p == 3) ? 25 : 70);
      while (beats_sent < stop_at) begin
        if ($urandom_range(0, 7) == 0)
          send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    4'($urandom_range(0, 15)), 1'b0, '0);
        else
          measure_once();
      end
    end

    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ultrasonic_echo_ranger_tb: clean");
    end else begin
      $display("ultrasonic_echo_ranger_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
